// File: src/assert_macros.svh
// assert_macros.svh: assertion macros shared by the trie lookup rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/utle_pkg.sv
// utle_pkg: types, codes and the symbol map of the url trie lookup engine
// no dependencies
package utle_pkg;

    localparam int SYMBOL_COUNT = 27;
    localparam int SYM_W        = 5;

    localparam logic [7:0] CHAR_A       = 8'h61;
    localparam logic [7:0] CHAR_Z       = 8'h7a;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [SYM_W-1:0] SLASH_INDEX = 5'd26;

    localparam logic [1:0] ACT_INS_CHAR  = 2'd0;
    localparam logic [1:0] ACT_SRCH_CHAR = 2'd1;
    localparam logic [1:0] ACT_FIN_INS   = 2'd2;
    localparam logic [1:0] ACT_FIN_SRCH  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_POOL_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD_SYMBOL = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
        logic [7:0] handler_id;
    } item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] result_id;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic       present;
        logic [7:0] id;
    } id_entry_t;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] idx;
    } sym_map_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic walk;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_finish;
        logic walk_go;
    } dp_sts_t;

    function automatic sym_map_t sym_map(input logic [7:0] b);
        sym_map_t m;
        m.ok  = 1'b0;
        m.idx = '0;
        if (b == CHAR_SLASH)
        begin
            m.ok  = 1'b1;
            m.idx = SLASH_INDEX;
        end
        else if (b >= CHAR_A && b <= CHAR_Z)
        begin
            m.ok  = 1'b1;
            m.idx = SYM_W'(b - CHAR_A);
        end
        return m;
    endfunction

endpackage

// File: src/utle_ram.sv
// utle_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module utle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/utle_ctrl.sv
// utle_ctrl: sequencing state machine of the trie lookup engine
// depends on utle_pkg and assert_macros.svh
`include "assert_macros.svh"
module utle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  utle_pkg::dp_sts_t sts,
    output utle_pkg::dp_cmd_t cmd
);
    import utle_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (sts.is_finish)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (sts.walk_go)
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:   state_next = S_IDLE;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_FINISH);
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.accept = (state_reg == S_IDLE) && start;
    assign cmd.walk   = (state_reg == S_WALK);
    assign cmd.finish = (state_reg == S_FINISH);

    `ASSERT_NEXT(a_finish_answers, clk, rst_n, start && !busy && sts.is_finish, done, "finish transaction gave no result")
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held for two cycles")
    `ASSERT_PROP(a_clear_busy, clk, rst_n, !cmd.clear || (busy && !done), "clearing pass not busy")

endmodule

// File: src/utle_datapath.sv
// utle_datapath: cursor, walk flags, node allocator, link and id memories
// depends on utle_pkg, utle_ram and assert_macros.svh
`include "assert_macros.svh"
module utle_datapath #(
    parameter int NODE_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  utle_pkg::dp_cmd_t cmd,
    output utle_pkg::dp_sts_t sts,
    input  utle_pkg::item_t   item,
    output utle_pkg::result_t result
);
    import utle_pkg::*;

    localparam int NW        = $clog2(NODE_COUNT);
    localparam int FW        = $clog2(NODE_COUNT + 1);
    localparam int SLOTS     = NODE_COUNT * SYMBOL_COUNT;
    localparam int SW        = $clog2(SLOTS);
    localparam int SLOT_LAST = SLOTS - 1;

    logic [NW-1:0] cursor_reg, cursor_next;
    logic          miss_reg, miss_next;
    logic [1:0]    err_reg, err_next;
    logic [FW-1:0] next_free_reg, next_free_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [SW-1:0] slot_reg;
    logic          ins_reg;
    logic          fin_ins_reg;
    logic [7:0]    hid_reg;

    sym_map_t      sm;
    logic          is_char;
    logic          sticky;
    logic [SW-1:0] slot_now;
    logic [NW-1:0] link_rdata;
    id_entry_t     id_rdata;
    logic          pool_full;
    logic          alloc;
    logic          id_store;

    logic          link_we;
    logic [SW-1:0] link_waddr;
    logic [NW-1:0] link_wdata;
    logic          id_we;
    logic [NW-1:0] id_waddr;
    id_entry_t     id_wdata;

    assign sm       = sym_map(item.symbol);
    assign is_char  = (item.action == ACT_INS_CHAR) || (item.action == ACT_SRCH_CHAR);
    assign sticky   = (err_reg != ST_OK) || miss_reg;
    assign slot_now = SW'(cursor_reg) * SW'(SYMBOL_COUNT) + SW'(sm.idx);

    assign sts.clear_done = (clr_cnt_reg == SW'(SLOT_LAST));
    assign sts.is_finish  = !is_char;
    assign sts.walk_go    = is_char && !sticky && sm.ok;

    assign pool_full = (next_free_reg == FW'(NODE_COUNT));
    assign alloc     = cmd.walk && (link_rdata == '0) && ins_reg && !pool_full;

    // answer of a finish transaction, from the id read issued at accept
    always_comb
    begin
        result.found     = 1'b0;
        result.result_id = '0;
        result.status    = ST_OK;
        id_store         = 1'b0;
        priority if (err_reg != ST_OK)
        begin
            result.status = err_reg;
        end
        else if (miss_reg)
        begin
            result.status = ST_NOT_FOUND;
        end
        else if (fin_ins_reg)
        begin
            id_store = 1'b1;
        end
        else if (id_rdata.present)
        begin
            result.found     = 1'b1;
            result.result_id = id_rdata.id;
        end
        else
        begin
            result.status = ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        miss_next      = miss_reg;
        err_next       = err_reg;
        next_free_next = next_free_reg;
        clr_cnt_next   = clr_cnt_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.accept && is_char && !sticky && !sm.ok)
        begin
            err_next = ST_BAD_SYMBOL;
        end
        if (cmd.walk)
        begin
            priority if (link_rdata != '0)
            begin
                cursor_next = link_rdata;
            end
            else if (!ins_reg)
            begin
                miss_next = 1'b1;
            end
            else if (pool_full)
            begin
                err_next = ST_POOL_FULL;
            end
            else
            begin
                cursor_next    = next_free_reg[NW-1:0];
                next_free_next = next_free_reg + 1'b1;
            end
        end
        if (cmd.finish)
        begin
            cursor_next = '0;
            miss_next   = 1'b0;
            err_next    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            miss_reg      <= 1'b0;
            err_reg       <= ST_OK;
            next_free_reg <= FW'(1);
            clr_cnt_reg   <= '0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            miss_reg      <= miss_next;
            err_reg       <= err_next;
            next_free_reg <= next_free_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg    <= slot_now;
            ins_reg     <= (item.action == ACT_INS_CHAR);
            fin_ins_reg <= (item.action == ACT_FIN_INS);
            hid_reg     <= item.handler_id;
        end
    end

    // clearing pass zeroes every link and the root id; a new node gets its id cleared
    assign link_we    = cmd.clear || alloc;
    assign link_waddr = cmd.clear ? clr_cnt_reg : slot_reg;
    assign link_wdata = cmd.clear ? '0 : next_free_reg[NW-1:0];

    assign id_we = cmd.clear || alloc || (cmd.finish && id_store);

    always_comb
    begin
        id_wdata = '0;
        priority if (cmd.clear)
        begin
            id_waddr = '0;
        end
        else if (alloc)
        begin
            id_waddr = next_free_reg[NW-1:0];
        end
        else
        begin
            id_waddr         = cursor_reg;
            id_wdata.present = 1'b1;
            id_wdata.id      = hid_reg;
        end
    end

    utle_ram #(
        .WIDTH (NW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.accept),
        .raddr (slot_now),
        .rdata (link_rdata)
    );

    utle_ram #(
        .WIDTH ($bits(id_entry_t)),
        .DEPTH (NODE_COUNT)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .re    (cmd.accept),
        .raddr (cursor_reg),
        .rdata (id_rdata)
    );

    `ASSERT_PROP(a_cursor_alloc, clk, rst_n, FW'(cursor_reg) < next_free_reg, "cursor on an unallocated node")
    `ASSERT_PROP(a_free_bound, clk, rst_n, next_free_reg <= FW'(NODE_COUNT) && next_free_reg != '0, "allocator out of range")
    `ASSERT_PROP(a_err_code, clk, rst_n, err_reg != ST_NOT_FOUND, "not-found latched as an error")

endmodule

// File: src/url_trie_lookup_engine_top.sv
// char transaction: a bad or ignored char leaves busy low; a walking char reads its link at
// acceptance, then steps with busy high; finish: done strobes in the cycle after acceptance
// a walking char or a finish holds busy high in the walk or finish state behind the registered
// memory read, so the next item waits; bad or ignored chars can be taken every cycle
// reset: after rst_n a clearing pass runs with busy high, zeroing the link memory; the receiver
// cannot stall, a result is shown for one cycle
module url_trie_lookup_engine_top #(
    parameter int NODE_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  utle_pkg::item_t   item,
    output logic              done,
    output utle_pkg::result_t result
);
    import utle_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    utle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    utle_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

endmodule

// File: bench/url_trie_lookup_engine_top_tb.sv
// self-checking bench for the url trie lookup engine: directed table, then random strings
// keeps its own trie for results the table leaves open; depends on utle_pkg and the rtl top
module url_trie_lookup_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utle_pkg::*;

    localparam int NODE_COUNT   = 256;
    localparam int ITEM_TARGET  = 1850;
    localparam int FLOOD_AT     = 900;
    localparam int FLOOD_LEN    = 300;
    localparam int KEY_MAX      = 8;
    localparam int KNOWN_MAX    = 64;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    // predictor state
    logic [7:0] trie_links [0:NODE_COUNT*SYMBOL_COUNT-1];
    id_entry_t  stored_ids [0:NODE_COUNT-1];
    int         free_node;
    int         cursor;
    bit         walk_miss;
    logic [1:0] walk_err;

    result_t  pending_results [$];
    dir_row_t dir_rows [$];

    logic [7:0] key_buf [0:KEY_MAX-1];
    int         key_len;
    logic [7:0] known_keys [0:KNOWN_MAX-1][0:KEY_MAX-1];
    int         known_len [0:KNOWN_MAX-1];
    int         known_count;

    int items_sent;
    int calm_left;
    int mismatches;
    int cycles;

    url_trie_lookup_engine_top #(.NODE_COUNT(NODE_COUNT)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    function automatic item_t make_item(input logic [1:0] a, input logic [7:0] s,
                                        input logic [7:0] h);
        item_t it;
        it.action     = a;
        it.symbol     = s;
        it.handler_id = h;
        return it;
    endfunction

    function automatic result_t make_result(input logic f, input logic [7:0] id,
                                            input logic [1:0] st);
        result_t r;
        r.found     = f;
        r.result_id = id;
        r.status    = st;
        return r;
    endfunction

    function automatic int symbol_slot(input logic [7:0] b);
        if (b == CHAR_SLASH)
            return SYMBOL_COUNT - 1;
        if (b >= CHAR_A && b <= CHAR_Z)
            return int'(b - CHAR_A);
        return -1;
    endfunction

    // mostly a narrow alphabet so prefixes get shared, now and then any byte, which may have no symbol
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0: return CHAR_A;
                1: return CHAR_A + 8'd1;
                2: return CHAR_A + 8'd2;
                default: return CHAR_SLASH;
            endcase
        end
        if (r < 97)
        begin
            if ($urandom_range(0, 26) == 26)
                return CHAR_SLASH;
            return CHAR_A + 8'($urandom_range(0, 25));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_bad_symbol();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (symbol_slot(b) >= 0)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic walk_trie(input item_t it, output bit has_res, output result_t res);
        int sidx;
        int slot;
        has_res = 1'b0;
        res     = '0;
        if (it.action == ACT_INS_CHAR || it.action == ACT_SRCH_CHAR)
        begin
            if (walk_err == ST_OK && !walk_miss)
            begin
                sidx = symbol_slot(it.symbol);
                if (sidx < 0)
                    walk_err = ST_BAD_SYMBOL;
                else
                begin
                    slot = cursor * SYMBOL_COUNT + sidx;
                    if (trie_links[slot] != '0)
                        cursor = trie_links[slot];
                    else if (it.action == ACT_SRCH_CHAR)
                        walk_miss = 1'b1;
                    else if (free_node >= NODE_COUNT)
                        walk_err = ST_POOL_FULL;
                    else
                    begin
                        trie_links[slot]      = 8'(free_node);
                        stored_ids[free_node] = '0;
                        cursor                = free_node;
                        free_node++;
                    end
                end
            end
        end
        else
        begin
            has_res = 1'b1;
            if (walk_err != ST_OK)
                res.status = walk_err;
            else if (walk_miss)
                res.status = ST_NOT_FOUND;
            else if (it.action == ACT_FIN_INS)
            begin
                stored_ids[cursor].present = 1'b1;
                stored_ids[cursor].id      = it.handler_id;
            end
            else if (stored_ids[cursor].present)
            begin
                res.found     = 1'b1;
                res.result_id = stored_ids[cursor].id;
            end
            else
                res.status = ST_NOT_FOUND;
            cursor    = 0;
            walk_miss = 1'b0;
            walk_err  = ST_OK;
        end
    endtask

    // drive one transaction, wait for it to be taken, then book its expected result
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        int      gap;
        bit      has_res;
        result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        walk_trie(it, has_res, res);
        if (has_res)
            pending_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic send_plain(input item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // walk key_buf, then finish; in mixed mode each char picks its own action
    task automatic send_key(input logic [1:0] char_act, input logic [1:0] fin_act,
                            input bit mixed);
        logic [1:0] a;
        for (int i = 0; i < key_len; i++)
        begin
            a = mixed ? 2'($urandom_range(0, 1)) : char_act;
            send_plain(make_item(a, key_buf[i], 8'($urandom_range(0, 255))));
        end
        send_plain(make_item(fin_act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    endtask

    task automatic fill_key(input int len);
        key_len = len;
        for (int i = 0; i < len; i++)
            key_buf[i] = pick_symbol();
    endtask

    task automatic remember_key();
        int slot;
        slot = (known_count < KNOWN_MAX) ? known_count : $urandom_range(0, KNOWN_MAX - 1);
        if (known_count < KNOWN_MAX)
            known_count++;
        known_len[slot] = key_len;
        for (int i = 0; i < key_len; i++)
            known_keys[slot][i] = key_buf[i];
    endtask

    task automatic add_row(input item_t it, input bit typed, input result_t want);
        dir_row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic note_failure(input string what, input result_t want, input result_t got);
        if (mismatches < REPORT_MAX)
            $display("%0t %s: expected found=%0d id=%02h status=%0d, got found=%0d id=%02h status=%0d",
                     $realtime, what, want.found, want.result_id, want.status,
                     got.found, got.result_id, got.status);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_failure("unexpected result", '0, result);
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found || result.result_id !== want.result_id ||
                    result.status !== want.status)
                    note_failure("result mismatch", want, result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int         kind;
        int         slot;
        logic [7:0] b;
        bit         flooded;

        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cycles      = 0;
        mismatches  = 0;
        items_sent  = 0;
        calm_left   = 0;
        known_count = 0;
        flooded     = 1'b0;
        for (int i = 0; i < NODE_COUNT * SYMBOL_COUNT; i++)
            trie_links[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++)
            stored_ids[i] = '0;
        free_node = 1;
        cursor    = 0;
        walk_miss = 1'b0;
        walk_err  = ST_OK;

        // empty strings on the root straight after reset
        add_row(make_item(ACT_FIN_SRCH, 8'h00, 8'h00), 1'b1, make_result(1'b0, 8'h00, ST_NOT_FOUND));
        add_row(make_item(ACT_FIN_INS, 8'h00, 8'hff), 1'b1, make_result(1'b0, 8'h00, ST_OK));
        add_row(make_item(ACT_FIN_SRCH, 8'hff, 8'h00), 1'b1, make_result(1'b1, 8'hff, ST_OK));
        // symbol extremes
        add_row(make_item(ACT_INS_CHAR, CHAR_A, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_INS_CHAR, CHAR_Z, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_INS_CHAR, CHAR_SLASH, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_INS, 8'h00, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_SRCH_CHAR, CHAR_A, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_SRCH_CHAR, CHAR_Z, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_SRCH_CHAR, CHAR_SLASH, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_SRCH, 8'h00, 8'h00), 1'b0, '0);
        // missing child, later chars of the string ignored
        add_row(make_item(ACT_SRCH_CHAR, CHAR_A + 8'd1, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_SRCH_CHAR, CHAR_A, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_SRCH, 8'h00, 8'h00), 1'b1, make_result(1'b0, 8'h00, ST_NOT_FOUND));
        // bytes just outside the symbol ranges
        add_row(make_item(ACT_INS_CHAR, CHAR_A - 8'd1, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_INS_CHAR, CHAR_A, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_INS, 8'h00, 8'h55), 1'b1, make_result(1'b0, 8'h00, ST_BAD_SYMBOL));
        add_row(make_item(ACT_SRCH_CHAR, CHAR_Z + 8'd1, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_SRCH, 8'h00, 8'h00), 1'b1, make_result(1'b0, 8'h00, ST_BAD_SYMBOL));
        // miss then finish insert stores nothing
        add_row(make_item(ACT_SRCH_CHAR, CHAR_A + 8'd16, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_INS, 8'h00, 8'h12), 1'b1, make_result(1'b0, 8'h00, ST_NOT_FOUND));
        // insert and search chars mixed in one string
        add_row(make_item(ACT_INS_CHAR, CHAR_A, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_SRCH_CHAR, CHAR_Z, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_INS_CHAR, CHAR_SLASH - 8'd1, 8'h00), 1'b0, '0);
        add_row(make_item(ACT_FIN_INS, 8'h00, 8'haa), 1'b0, '0);
        add_row(make_item(ACT_FIN_SRCH, 8'h00, 8'h00), 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        while (items_sent < ITEM_TARGET)
        begin
            if (!flooded && items_sent >= FLOOD_AT)
            begin
                // one deep chain that runs the node pool dry
                flooded = 1'b1;
                for (int i = 0; i < FLOOD_LEN; i++)
                    send_plain(make_item(ACT_INS_CHAR, CHAR_A + 8'($urandom_range(0, 25)),
                                         8'($urandom_range(0, 255))));
                send_plain(make_item(ACT_FIN_INS, 8'h00, 8'($urandom_range(0, 255))));
            end
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                fill_key($urandom_range(0, 6));
                send_key(ACT_INS_CHAR, ACT_FIN_INS, 1'b0);
                remember_key();
            end
            else if (kind < 65 && known_count > 0)
            begin
                slot    = $urandom_range(0, known_count - 1);
                key_len = known_len[slot];
                for (int i = 0; i < key_len; i++)
                    key_buf[i] = known_keys[slot][i];
                kind = $urandom_range(0, 99);
                if (kind >= 70 && kind < 85 && key_len > 0)
                    key_len--;
                else if (kind >= 85 && key_len < KEY_MAX)
                begin
                    key_buf[key_len] = pick_symbol();
                    key_len++;
                end
                send_key(ACT_SRCH_CHAR, ACT_FIN_SRCH, 1'b0);
            end
            else if (kind < 80)
            begin
                fill_key($urandom_range(0, 6));
                send_key(ACT_SRCH_CHAR, ACT_FIN_SRCH, 1'b0);
            end
            else if (kind < 88)
            begin
                fill_key($urandom_range(1, 6));
                send_key(ACT_INS_CHAR, $urandom_range(0, 1) ? ACT_FIN_INS : ACT_FIN_SRCH, 1'b1);
            end
            else if (kind < 95)
            begin
                fill_key($urandom_range(1, 6));
                key_buf[$urandom_range(0, key_len - 1)] = pick_bad_symbol();
                send_key($urandom_range(0, 1) ? ACT_INS_CHAR : ACT_SRCH_CHAR,
                         $urandom_range(0, 1) ? ACT_FIN_INS : ACT_FIN_SRCH, 1'b0);
            end
            else
            begin
                // raw noise, any action and any byte
                for (int i = $urandom_range(1, 4); i > 0; i--)
                begin
                    b = 8'($urandom_range(0, 255));
                    send_plain(make_item(2'($urandom_range(0, 3)), b, 8'($urandom_range(0, 255))));
                end
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
